// ===== hdl/sclfu_pkg.sv =====
// Shared constants, codes and types of the sector cache LFU policy core.
// Used by the cell module and by the top level; depends on nothing.
package sclfu_pkg;

  localparam int NUM_ENTRIES = 8;
  localparam int COUNT_BITS  = 8;
  localparam int ENTRY_BITS  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int SECTOR_BITS = 32;
  localparam int STATUS_BITS = 2;
  localparam int ENTRY_FIELD_BITS = 3;
  localparam int OUT_DATA_BITS = 8;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_ALLOC  = 1'b1;

  localparam logic [STATUS_BITS-1:0] ST_HIT   = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_MISS  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_ALLOC = 2'd2;

  typedef logic [ENTRY_BITS-1:0] entry_idx_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [COUNT_BITS:0]   best_count_t;

  // Search record handed from cell to cell.
  typedef struct packed {
    logic                   op;
    logic [SECTOR_BITS-1:0] sector;
    logic                   fin;
    logic                   found;
    entry_idx_t             idx;
    best_count_t            best_cnt;
  } carry_t;

  // State update broadcast to all cells when a completed item hits or allocates.
  typedef struct packed {
    logic                   we;
    logic                   alloc;
    entry_idx_t             idx;
    logic [SECTOR_BITS-1:0] sector;
  } upd_t;

endpackage

// ===== hdl/sclfu_cell.sv =====
// One cache entry cell: holds tag, valid bit and read count, and extends
// the search record passed along the chain. Depends on sclfu_pkg.
module sclfu_cell import sclfu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  entry_idx_t cell_idx,
  input  logic       carry_vld_i,
  input  carry_t     carry_i,
  input  logic       hold,
  input  upd_t       upd,
  output logic       carry_vld_r,
  output carry_t     carry_r,
  output logic       valid_o
);

  logic [SECTOR_BITS-1:0] tag_r;
  logic                   valid_r;
  count_t                 count_r;
  carry_t                 carry_nxt;
  logic                   sel;

  always_comb begin
    carry_nxt = carry_i;
    if (carry_i.op == OP_LOOKUP) begin
      if (!carry_i.found && valid_r && (tag_r == carry_i.sector)) begin
        carry_nxt.found = 1'b1;
        carry_nxt.idx   = cell_idx;
      end
    end else begin
      if ({1'b0, count_r} < carry_i.best_cnt) begin
        carry_nxt.best_cnt = {1'b0, count_r};
        carry_nxt.idx      = cell_idx;
      end
    end
  end

  assign sel = upd.we && (upd.idx == cell_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      count_r     <= '0;
      carry_vld_r <= 1'b0;
    end else begin
      carry_vld_r <= carry_vld_i | (carry_vld_r & hold);
      if (sel) begin
        if (upd.alloc) begin
          valid_r <= 1'b1;
          count_r <= count_t'(1);
        end else if (count_r != {COUNT_BITS{1'b1}}) begin
          count_r <= count_r + count_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel && upd.alloc) begin
      tag_r <= upd.sector;
    end
    if (carry_vld_i) begin
      carry_r <= carry_nxt;
    end
  end

  assign valid_o = valid_r;

endmodule

// ===== hdl/sector_cache_lfu_policy_core.sv =====
// The search record walks the cell chain one entry per cycle, waiting at the
// last cell while a result at the output is not taken, and only one item is
// in flight, so a new input item is accepted only once the last one is done.
// A result waiting at the output does not block the next input item.
// Reset (rst_n low, synchronous) invalidates all entries and clears counts.
// Depends on sclfu_pkg and sclfu_cell.
module sector_cache_lfu_policy_core import sclfu_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [SECTOR_BITS-1:0]   in_tdata,   // [31:0] sector
  input  logic                     in_tuser,   // [0] op
  input  logic                     in_tlast,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata,  // [2:0] entry, [7:3] zero
  output logic [STATUS_BITS-1:0]   out_tuser,  // [1:0] status
  output logic                     out_tlast
);

  logic   busy_r;
  logic   in_acc;
  logic   take;
  carry_t head;
  upd_t   upd;

  logic   [NUM_ENTRIES-1:0] vld_vec;
  logic   [NUM_ENTRIES-1:0] valid_vec;
  carry_t                   carry_vec [NUM_ENTRIES];

  logic                         out_valid_r;
  logic [ENTRY_FIELD_BITS-1:0]  out_entry_r;
  logic [STATUS_BITS-1:0]       out_status_r;
  logic                         out_last_r;
  logic [ENTRY_FIELD_BITS-1:0]  res_entry;
  logic [STATUS_BITS-1:0]       res_status;
  carry_t                       tail;

  assign in_tready = !busy_r;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    head.op       = in_tuser;
    head.sector   = in_tdata;
    head.fin      = in_tlast;
    head.found    = 1'b0;
    head.idx      = '0;
    head.best_cnt = {1'b1, {COUNT_BITS{1'b0}}};
  end

  assign tail = carry_vec[NUM_ENTRIES-1];
  assign take = vld_vec[NUM_ENTRIES-1] && (!out_valid_r || out_tready);

  always_comb begin
    upd.we     = take && ((tail.op == OP_ALLOC) || tail.found);
    upd.alloc  = (tail.op == OP_ALLOC);
    upd.idx    = tail.idx;
    upd.sector = tail.sector;
  end

  for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_cell
    logic   cvld;
    carry_t cin;
    logic   chold;
    if (i == 0) begin : g_first
      assign cvld = in_acc;
      assign cin  = head;
    end else begin : g_next
      assign cvld = vld_vec[i-1];
      assign cin  = carry_vec[i-1];
    end
    assign chold = (i == NUM_ENTRIES - 1) ? !take : 1'b0;

    sclfu_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cell_idx    (ENTRY_BITS'(i)),
      .carry_vld_i (cvld),
      .carry_i     (cin),
      .hold        (chold),
      .upd         (upd),
      .carry_vld_r (vld_vec[i]),
      .carry_r     (carry_vec[i]),
      .valid_o     (valid_vec[i])
    );
  end

  always_comb begin
    if (tail.op == OP_ALLOC) begin
      res_status = ST_ALLOC;
      res_entry  = ENTRY_FIELD_BITS'(tail.idx);
    end else if (tail.found) begin
      res_status = ST_HIT;
      res_entry  = ENTRY_FIELD_BITS'(tail.idx);
    end else begin
      res_status = ST_MISS;
      res_entry  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        busy_r <= 1'b1;
      end else if (take) begin
        busy_r <= 1'b0;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_entry_r  <= res_entry;
      out_status_r <= res_status;
      out_last_r   <= tail.fin;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_BITS-ENTRY_FIELD_BITS){1'b0}}, out_entry_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(vld_vec))
    else $error("more than one item in the cell chain");

  a_busy_tracks_chain: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r == (|vld_vec))
    else $error("busy flag disagrees with the cell chain");

  a_take_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_tvalid)
    else $error("completed item did not reach the output");

  a_alloc_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (take && (tail.op == OP_ALLOC)) |=> valid_vec[$past(tail.idx)])
    else $error("allocated entry is not valid");

endmodule
